// File: design/itrn_pkg.sv
// Shared types, constants and the denomination table for the Roman numeral encoder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package itrn_pkg;

   localparam int NUMBER_W = 16;
   localparam int REST_W = 12;
   localparam int CHAR_W = 8;
   localparam int DENOM_COUNT = 13;
   localparam int DENOM_IDX_W = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [NUMBER_W-1:0] MAX_NUMERAL = 16'd3999;

   localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_I = 8'h49;
   localparam logic [CHAR_W-1:0] CHAR_V = 8'h56;
   localparam logic [CHAR_W-1:0] CHAR_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_L = 8'h4C;
   localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_D = 8'h44;
   localparam logic [CHAR_W-1:0] CHAR_M = 8'h4D;

   localparam logic [REST_W-1:0] DENOM_WORTH [DENOM_COUNT] = '{
      12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
      12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
   };

   localparam logic [CHAR_W-1:0] DENOM_FIRST [DENOM_COUNT] = '{
      CHAR_M, CHAR_C, CHAR_D, CHAR_C, CHAR_C, CHAR_X, CHAR_L,
      CHAR_X, CHAR_X, CHAR_I, CHAR_V, CHAR_I, CHAR_I
   };

   // CHAR_NONE marks a one-character denomination
   localparam logic [CHAR_W-1:0] DENOM_SECOND [DENOM_COUNT] = '{
      CHAR_NONE, CHAR_M, CHAR_NONE, CHAR_D, CHAR_NONE, CHAR_C, CHAR_NONE,
      CHAR_L, CHAR_NONE, CHAR_X, CHAR_NONE, CHAR_V, CHAR_NONE
   };

   typedef enum logic [1:0] {
      KIND_NUMBER = 2'd0,
      KIND_ZERO   = 2'd1,
      KIND_RANGE  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [REST_W-1:0]   value;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Largest denomination not above rest; rest is non-zero when used.
   function automatic logic [DENOM_IDX_W-1:0] denom_select(input logic [REST_W-1:0] rest);
      logic [DENOM_IDX_W-1:0] sel;
      sel = DENOM_IDX_W'(DENOM_COUNT - 1);
      for (int i = DENOM_COUNT - 1; i >= 0; i--) begin
         if (rest >= DENOM_WORTH[i]) begin
            sel = DENOM_IDX_W'(i);
         end
      end
      return sel;
   endfunction

endpackage

`default_nettype wire

// File: design/integer_to_roman_numeral.sv
// From idle, a transfer is queued, then popped into the engine that drives the result.
// Throughput: one character per cycle; a number gives 1 to 15 characters in the
// character engine (3888 gives fifteen), numbers follow back to back.
// busy is high while the QUEUE_DEPTH-entry queue is full; results cannot be stalled.
// Reset is synchronous: it empties the queue and idles the engine, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_roman_numeral #(
   parameter int QUEUE_DEPTH = itrn_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [itrn_pkg::NUMBER_W-1:0]    req_number_value,
   output logic                             rsp_strobe,
   output logic [itrn_pkg::CHAR_W-1:0]      rsp_numeral_char,
   output logic                             rsp_last_char,
   output logic                             rsp_empty_numeral,
   output logic                             rsp_out_of_range
);
   import itrn_pkg::*;

   queue_status_type  status;
   entry_type         push_entry;
   entry_type         pop_entry;
   logic              push;
   logic              pop;

   itrn_front u_front (
      .start            (start),
      .busy             (busy),
      .req_number_value (req_number_value),
      .status           (status),
      .push             (push),
      .push_entry       (push_entry)
   );

   itrn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (status)
   );

   itrn_back u_back (
      .clock             (clock),
      .reset             (reset),
      .status            (status),
      .pop_entry         (pop_entry),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_numeral_char  (rsp_numeral_char),
      .rsp_last_char     (rsp_last_char),
      .rsp_empty_numeral (rsp_empty_numeral),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

`default_nettype wire

// File: design/itrn_front.sv
// Front end: takes a number on the start/busy handshake and classifies it.
// Depends on itrn_pkg; feeds itrn_queue.
`timescale 1ns / 1ps
`default_nettype none

module itrn_front (
   input  logic                             start,
   output logic                             busy,
   input  logic [itrn_pkg::NUMBER_W-1:0]    req_number_value,
   input  itrn_pkg::queue_status_type       status,
   output logic                             push,
   output itrn_pkg::entry_type              push_entry
);
   import itrn_pkg::*;

   assign busy = status.full;
   assign push = start && !status.full;

   always_comb begin
      push_entry.value = req_number_value[REST_W-1:0];
      if (req_number_value == '0) begin
         push_entry.kind = KIND_ZERO;
      end else if (req_number_value > MAX_NUMERAL) begin
         push_entry.kind = KIND_RANGE;
      end else begin
         push_entry.kind = KIND_NUMBER;
      end
   end

endmodule

`default_nettype wire

// File: design/itrn_queue.sv
// Short queue of classified numbers between front end and character engine.
// Depends on itrn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itrn_queue #(
   parameter int DEPTH = itrn_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  itrn_pkg::entry_type         push_entry,
   input  logic                        pop,
   output itrn_pkg::entry_type         pop_entry,
   output itrn_pkg::queue_status_type  status
);
   import itrn_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_entry    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: design/itrn_back.sv
// Character engine: pops a classified number and emits one numeral character a cycle.
// Depends on itrn_pkg; fed by itrn_queue.
`timescale 1ns / 1ps
`default_nettype none

module itrn_back (
   input  logic                             clock,
   input  logic                             reset,
   input  itrn_pkg::queue_status_type       status,
   input  itrn_pkg::entry_type              pop_entry,
   output logic                             pop,
   output logic                             rsp_strobe,
   output logic [itrn_pkg::CHAR_W-1:0]      rsp_numeral_char,
   output logic                             rsp_last_char,
   output logic                             rsp_empty_numeral,
   output logic                             rsp_out_of_range
);
   import itrn_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   kind_type                kind_ff, kind_in;
   logic [REST_W-1:0]       rest_ff, rest_in;
   logic                    pend_ff, pend_in;
   logic [CHAR_W-1:0]       second_ff, second_in;
   logic [REST_W-1:0]       rest_step;
   logic                    pend_step;
   logic [DENOM_IDX_W-1:0]  sel;
   logic [REST_W-1:0]       diff;
   logic                    finish;

   assign sel  = denom_select(rest_ff);
   assign diff = rest_ff - DENOM_WORTH[sel];

   always_comb begin
      rsp_strobe        = 1'b0;
      rsp_numeral_char  = CHAR_NONE;
      rsp_last_char     = 1'b0;
      rsp_empty_numeral = 1'b0;
      rsp_out_of_range  = 1'b0;
      rest_step         = rest_ff;
      pend_step         = pend_ff;
      second_in         = second_ff;
      if (state_ff == ST_RUN) begin
         rsp_strobe = 1'b1;
         unique case (kind_ff)
            KIND_ZERO: begin
               rsp_empty_numeral = 1'b1;
               rsp_last_char     = 1'b1;
            end
            KIND_RANGE: begin
               rsp_out_of_range = 1'b1;
               rsp_last_char    = 1'b1;
            end
            KIND_NUMBER: begin
               if (pend_ff) begin
                  // second half of a subtractive pair; rest already reduced
                  rsp_numeral_char = second_ff;
                  rsp_last_char    = (rest_ff == '0);
                  pend_step        = 1'b0;
               end else begin
                  rsp_numeral_char = DENOM_FIRST[sel];
                  rest_step        = diff;
                  if (DENOM_SECOND[sel] != CHAR_NONE) begin
                     pend_step = 1'b1;
                     second_in = DENOM_SECOND[sel];
                  end else begin
                     rsp_last_char = (diff == '0);
                  end
               end
            end
            default: begin
               rsp_last_char = 1'b1;
            end
         endcase
      end
   end

   assign finish = rsp_strobe && rsp_last_char;
   // take the next number in the cycle the current one ends
   assign pop    = !status.empty && ((state_ff == ST_IDLE) || finish);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      rest_in  = rest_step;
      pend_in  = pend_step;
      if (pop) begin
         state_in = ST_RUN;
         kind_in  = pop_entry.kind;
         rest_in  = pop_entry.value;
         pend_in  = 1'b0;
      end else if (finish) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      rest_ff   <= rest_in;
      second_ff <= second_in;
   end

endmodule

`default_nettype wire

// File: design/itrn_checker.sv
// Port-level checks on the Roman numeral encoder, bound to the top level.
// Depends on itrn_pkg and integer_to_roman_numeral.
`timescale 1ns / 1ps
`default_nettype none

module itrn_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [itrn_pkg::NUMBER_W-1:0]    req_number_value,
   input  logic                             rsp_strobe,
   input  logic [itrn_pkg::CHAR_W-1:0]      rsp_numeral_char,
   input  logic                             rsp_last_char,
   input  logic                             rsp_empty_numeral,
   input  logic                             rsp_out_of_range
);
   import itrn_pkg::*;

   // flagged results stand alone and carry no character
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_empty_numeral || rsp_out_of_range)
      |-> rsp_last_char && (rsp_numeral_char == CHAR_NONE)
          && !(rsp_empty_numeral && rsp_out_of_range))
      else $error("flagged result malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_empty_numeral && !rsp_out_of_range
      |-> (rsp_numeral_char == CHAR_I) || (rsp_numeral_char == CHAR_V)
          || (rsp_numeral_char == CHAR_X) || (rsp_numeral_char == CHAR_L)
          || (rsp_numeral_char == CHAR_C) || (rsp_numeral_char == CHAR_D)
          || (rsp_numeral_char == CHAR_M))
      else $error("result character is not a numeral letter");

   // characters of one numeral follow without a gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_char |=> rsp_strobe)
      else $error("gap inside a numeral");

   assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   // a transfer into an idle block is answered once it has passed the queue and the engine state
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && !rsp_strobe && !$past(start && !busy) |-> ##2 rsp_strobe)
      else $error("first result late");

endmodule

bind integer_to_roman_numeral itrn_checker u_checker (.*);

`default_nettype wire
